// ===== src/two_list_sorted_merge_unit_macros.svh =====
// Assertion macros for the two-list sorted merge unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef TWO_LIST_SORTED_MERGE_UNIT_MACROS_SVH
`define TWO_LIST_SORTED_MERGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define TLSM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tlsm invariant violated");

`define TLSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlsm same-cycle check failed");

`define TLSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlsm next-cycle check failed");

`else

`define TLSM_ASSERT_ALWAYS(lbl, cond)
`define TLSM_ASSERT_IMP(lbl, ante, cons)
`define TLSM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/tlsm_pkg.sv =====
// Shared constants for the two-list sorted merge unit.
// Used by the channel interfaces and the top level; no dependencies.
package tlsm_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 2;
  localparam int DEPTH_DEFAULT = 32;

  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

endpackage

// ===== src/tlsm_ifs.sv =====
// Valid/ready channel interfaces for the two-list sorted merge unit.
// Depends on tlsm_pkg for field widths.

interface tlsm_in_if
  import tlsm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface tlsm_out_if
  import tlsm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last;

  modport source (output valid, merged_value, last, input ready);
  modport sink   (input valid, merged_value, last, output ready);
endinterface

// ===== src/two_list_sorted_merge_unit.sv =====
// Two-list sorted merge unit.
// in_ch takes one word per accepted handshake: op 0 appends value to list A,
// op 1 appends it to list B, op 2 merges both lists and op 3 is ignored.
// An append to a full list (DEPTH entries) is dropped; appends give no result.
// A merge streams the merged run on out_ch, smallest head first; on equal
// heads the A word goes out and then the B word. The final word carries last.
// After the run both lists are empty. Merging two empty lists gives nothing.
// For each output word, S_READ reads both list heads from their memories
// into registers and S_CMP compares them with the single signed comparator
// and loads the output register; the B word of a tie is loaded from S_PUSH_B
// with no new read.
// in_ch.ready is low for the whole merge and high again once the final word
// sits in the output register, even if the receiver has not yet taken it.
// When out_ch.ready is low, the held word stays in place and the merge
// sequencer waits. Synchronous active-low reset empties both lists and
// drops any pending output word; list contents are not cleared.
// Depends on tlsm_pkg, tlsm_ifs and two_list_sorted_merge_unit_macros.svh.
`include "two_list_sorted_merge_unit_macros.svh"

module two_list_sorted_merge_unit
  import tlsm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  tlsm_in_if.sink     in_ch,
  tlsm_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PUSH_B
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0]         ia_r, ib_r;
  logic [CNT_W-1:0]         ia_inc, ib_inc;
  logic [DATA_W-1:0]        mem_a [DEPTH];
  logic [DATA_W-1:0]        mem_b [DEPTH];
  logic [DATA_W-1:0]        rd_a_r, rd_b_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_value_r;
  logic                     out_last_r;

  logic in_acc;
  logic wr_a, wr_b;
  logic a_avail, b_avail;
  logic a_lt_b, a_eq_b;
  logic take_a, tie;
  logic slot_free;
  logic cmp_last, pb_last;
  logic emit, emit_last;
  logic lists_empty, idle_empty;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid & in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.merged_value = out_value_r;
  assign out_ch.last         = out_last_r;

  assign wr_a = in_acc && (in_ch.op == OP_APPEND_A) && (cnt_a_r < CNT_W'(DEPTH));
  assign wr_b = in_acc && (in_ch.op == OP_APPEND_B) && (cnt_b_r < CNT_W'(DEPTH));

  assign lists_empty = (cnt_a_r == '0) && (cnt_b_r == '0);
  assign idle_empty  = (state_r == S_IDLE) && lists_empty;

  assign ia_inc  = ia_r + CNT_W'(1);
  assign ib_inc  = ib_r + CNT_W'(1);
  assign a_avail = (ia_r < cnt_a_r);
  assign b_avail = (ib_r < cnt_b_r);

  // The one shared comparator that orders the two list heads.
  assign a_lt_b = ($signed(rd_a_r) < $signed(rd_b_r));
  assign a_eq_b = (rd_a_r == rd_b_r);
  assign take_a = a_avail && (!b_avail || a_lt_b || a_eq_b);
  assign tie    = a_avail && b_avail && a_eq_b;

  assign slot_free = !out_valid_r || out_ch.ready;

  // A word is last when it empties its own list and the other is already empty.
  // On a tie the A word is never last because its B partner follows.
  always_comb begin
    if (take_a) begin
      cmp_last = !tie && (ia_inc == cnt_a_r) && !b_avail;
    end else begin
      cmp_last = (ib_inc == cnt_b_r) && !a_avail;
    end
  end
  assign pb_last = !a_avail && (ib_inc == cnt_b_r);

  assign emit      = slot_free && ((state_r == S_CMP) || (state_r == S_PUSH_B));
  assign emit_last = (state_r == S_CMP) ? cmp_last : pb_last;

  // List memories: one write port for appends, one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= in_ch.value;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= in_ch.value;
    end
    rd_a_r <= mem_a[ia_r[IDX_W-1:0]];
    rd_b_r <= mem_b[ib_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new word loaded this cycle keeps the valid flag set.
      if (out_ch.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.op)
              OP_APPEND_A: begin
                if (wr_a) begin
                  cnt_a_r <= cnt_a_r + CNT_W'(1);
                end
              end
              OP_APPEND_B: begin
                if (wr_b) begin
                  cnt_b_r <= cnt_b_r + CNT_W'(1);
                end
              end
              OP_MERGE: begin
                if (!lists_empty) begin
                  ia_r    <= '0;
                  ib_r    <= '0;
                  state_r <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= take_a ? rd_a_r : rd_b_r;
            out_last_r  <= cmp_last;
            if (take_a) begin
              ia_r <= ia_inc;
            end else begin
              ib_r <= ib_inc;
            end
            if (tie) begin
              state_r <= S_PUSH_B;
            end else if (cmp_last) begin
              cnt_a_r <= '0;
              cnt_b_r <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_PUSH_B: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= rd_b_r;
            out_last_r  <= pb_last;
            ib_r        <= ib_inc;
            if (pb_last) begin
              cnt_a_r <= '0;
              cnt_b_r <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Read indexes keep their final values after a run, so they are bounded only mid-merge.
  `TLSM_ASSERT_ALWAYS(a_cnt_bound, (cnt_a_r <= CNT_W'(DEPTH)) && (cnt_b_r <= CNT_W'(DEPTH)))
  `TLSM_ASSERT_ALWAYS(a_idx_bound, (state_r == S_IDLE) || ((ia_r <= cnt_a_r) && (ib_r <= cnt_b_r)))
  `TLSM_ASSERT_NEXT(a_merge_start, in_acc && (in_ch.op == OP_MERGE) && !lists_empty, state_r == S_READ)
  `TLSM_ASSERT_NEXT(a_last_ends_run, emit && emit_last, idle_empty && out_valid_r && out_last_r)

endmodule

// ===== tb/sv/two_list_sorted_merge_unit_tb.sv =====
// Self-checking testbench for the two-list sorted merge unit: loads both lists,
// merges, and checks every streamed word against its own merge predictor.
// Depends on tlsm_pkg, tlsm_ifs and the two_list_sorted_merge_unit RTL.
`timescale 1ns / 1ps

module two_list_sorted_merge_unit_tb
  import tlsm_pkg::*;
();

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t word_q_t[$];

  typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BURSTY} stall_mode_t;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 150;

  // Mirrors both lists and works out the merged run for every merge request.
  class merged_run_predictor;
    int    depth;
    word_t list_a_copy[$];
    word_t list_b_copy[$];
    word_t due_words[$];
    logic  due_last[$];
    int    errors;
    int    checked;
    int    merges;
    int    ignored;
    int    longest_run;

    function new(int depth_i);
      depth = depth_i;
    endfunction

    function void note_word(logic [OP_W-1:0] op, word_t value);
      int ia;
      int ib;
      int first;
      ia = 0;
      ib = 0;
      first = due_words.size();
      case (op)
        OP_APPEND_A: begin
          if (list_a_copy.size() < depth) list_a_copy.push_back(value);
        end
        OP_APPEND_B: begin
          if (list_b_copy.size() < depth) list_b_copy.push_back(value);
        end
        OP_MERGE: begin
          merges++;
          while (ia < list_a_copy.size() && ib < list_b_copy.size()) begin
            if (list_a_copy[ia] < list_b_copy[ib]) begin
              due_words.push_back(list_a_copy[ia++]);
            end else if (list_a_copy[ia] > list_b_copy[ib]) begin
              due_words.push_back(list_b_copy[ib++]);
            end else begin
              due_words.push_back(list_a_copy[ia++]);
              due_words.push_back(list_b_copy[ib++]);
            end
          end
          while (ia < list_a_copy.size()) due_words.push_back(list_a_copy[ia++]);
          while (ib < list_b_copy.size()) due_words.push_back(list_b_copy[ib++]);
          for (int k = first; k < due_words.size(); k++) begin
            due_last.push_back(k == due_words.size() - 1);
          end
          if (due_words.size() - first > longest_run) longest_run = due_words.size() - first;
          list_a_copy.delete();
          list_b_copy.delete();
        end
        default: begin
          ignored++;
        end
      endcase
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_word(word_t value, logic last);
      word_t want_value;
      logic  want_last;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d last=%0b", value, last));
        return;
      end
      want_value = due_words.pop_front();
      want_last  = due_last.pop_front();
      checked++;
      if (value !== want_value) begin
        report_mismatch($sformatf("merged_value %0d, expected %0d", value, want_value));
      end
      if (last !== want_last) begin
        report_mismatch($sformatf("last %0b, expected %0b (value %0d)", last, want_last,
                                  want_value));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  tlsm_in_if  in_ch();
  tlsm_out_if out_ch();

  two_list_sorted_merge_unit #(
    .DEPTH (DEPTH_DEFAULT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  merged_run_predictor runs;
  int words_sent;
  int burst_left;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drives one word, waits for it to be taken, then maybe opens an idle gap.
  task automatic send_word(logic [OP_W-1:0] op, word_t value);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.value = value;
    do @(posedge clk); while (!in_ch.ready);
    runs.note_word(op, value);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        in_ch.op    = OP_W'($urandom());
        in_ch.value = $urandom();
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Holds the sender off until the whole expected run has been streamed.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (runs.pending() > 0) @(posedge clk);
  endtask

  // Ascending values; a narrow span makes equal heads across the lists likely.
  function automatic word_q_t sorted_words(int n, bit narrow);
    word_q_t q;
    longint  acc;
    acc = narrow ? longint'($urandom_range(0, 6)) - 3 : longint'(int'($urandom()));
    for (int k = 0; k < n; k++) begin
      if (acc > longint'(WORD_MAX)) acc = longint'(WORD_MAX);
      q.push_back(acc[DATA_W-1:0]);
      acc += narrow ? longint'($urandom_range(0, 2)) : longint'($urandom_range(0, 32'h0fff_ffff));
    end
    return q;
  endfunction

  // Interleaves the two sorted lists, sprinkles in some noise, then merges.
  task automatic load_and_merge(int n_a, int n_b, bit narrow);
    word_q_t wa;
    word_q_t wb;
    int      ia;
    int      ib;
    wa = sorted_words(n_a, narrow);
    wb = sorted_words(n_b, narrow);
    ia = 0;
    ib = 0;
    while (ia < n_a || ib < n_b) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(OP_NONE, $urandom());
      end else if ($urandom_range(0, 59) == 0) begin
        send_word(OP_MERGE, $urandom());
      end else if (ib >= n_b || (ia < n_a && $urandom_range(0, 1) == 1)) begin
        send_word(OP_APPEND_A, ($urandom_range(0, 24) == 0) ? word_t'($urandom()) : wa[ia]);
        ia++;
      end else begin
        send_word(OP_APPEND_B, ($urandom_range(0, 24) == 0) ? word_t'($urandom()) : wb[ib]);
        ib++;
      end
    end
    send_word(OP_MERGE, $urandom());
  endtask

  // Receiver: ready follows a stall pattern that is drawn anew at random whenever the current one runs out.
  initial begin
    stall_mode_t mode;
    int          left;
    int          phase;
    mode  = STALL_NONE;
    left  = 0;
    phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(10, 80);
      end
      left--;
      phase++;
      case (mode)
        STALL_NONE:   out_ch.ready = 1'b1;
        STALL_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
        STALL_SPARSE: out_ch.ready = (phase % 4 == 0);
        default:      out_ch.ready = (phase % 5 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      runs.check_word(out_ch.merged_value, out_ch.last);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
          $display("two_list_sorted_merge_unit_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int n_a;
    int n_b;
    runs        = new(DEPTH_DEFAULT);
    words_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_APPEND_A;
    in_ch.value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Merge of two empty lists, then an unknown op.
    send_word(OP_MERGE, WORD_MAX);
    send_word(OP_NONE, word_t'(32'hffff_ffff));
    // Extremes of the value range and equal heads.
    send_word(OP_APPEND_A, WORD_MIN);
    send_word(OP_APPEND_A, 0);
    send_word(OP_APPEND_B, WORD_MIN);
    send_word(OP_APPEND_A, 7);
    send_word(OP_APPEND_B, 7);
    send_word(OP_APPEND_B, WORD_MAX);
    send_word(OP_MERGE, 0);
    // Lists out of order still follow the head comparison.
    send_word(OP_APPEND_A, 5);
    send_word(OP_APPEND_A, -3);
    send_word(OP_APPEND_B, 4);
    send_word(OP_NONE, 0);
    send_word(OP_MERGE, 0);
    // Only one list holds data.
    send_word(OP_APPEND_A, WORD_MAX);
    send_word(OP_MERGE, WORD_MIN);
    send_word(OP_APPEND_B, -1);
    send_word(OP_MERGE, -1);

    // Both lists overfilled, so the appends past the end are dropped.
    load_and_merge(DEPTH_DEFAULT + 2, DEPTH_DEFAULT + 1, 1'($urandom_range(0, 1)));
    drain();

    // Long loads only while there is room left in the word budget.
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0 &&
          (RANDOM_WORDS - words_sent > DEPTH_DEFAULT * 2 + 8)) begin
        n_a = $urandom_range(DEPTH_DEFAULT - 2, DEPTH_DEFAULT + 2);
        n_b = $urandom_range(0, DEPTH_DEFAULT + 2);
      end else begin
        n_a = $urandom_range(0, 6);
        n_b = $urandom_range(0, 6);
      end
      load_and_merge(n_a, n_b, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d input words, %0d merges, %0d unknown ops; %0d merged words checked",
             words_sent, runs.merges, runs.ignored, runs.checked);
    $display("longest merged run %0d words, %0d mismatches", runs.longest_run, runs.errors);
    if (runs.errors == 0 && runs.pending() == 0) begin
      $display("two_list_sorted_merge_unit_tb: done, clean");
    end else begin
      $display("two_list_sorted_merge_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
